// ===== src/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg: shared types and codes of the touch slot tracker
// Request kinds, the controller state type and the
// command bundle sent from the controller to the datapath.
// ----------------------------------------------------------------------------
package tst_pkg;

    typedef enum logic [2:0] {
        K_BEGIN = 3'd0,
        K_MOVE  = 3'd1,
        K_END   = 3'd2,
        K_TICK  = 3'd3,
        K_CLEAR = 3'd4,
        K_NTH   = 3'd5,
        K_IDQ   = 3'd6,
        K_NONE  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic search;
        logic apply;
        logic result;
    } t_cmd;

endpackage

// ===== src/tst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tst_ctrl: sequencer of the touch slot tracker
// Steps each request through search, apply and result phases.
// ----------------------------------------------------------------------------
module tst_ctrl
    import tst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_out_free,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/tst_datapath.sv =====
// ----------------------------------------------------------------------------
// tst_datapath: slot table, searches and result register
// The slot table lives in flip-flops; a search picks one slot, the apply
// step updates the table, the result step loads the output register.
// ----------------------------------------------------------------------------
module tst_datapath
    import tst_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [80:0]  i_req,
    input  t_cmd         i_cmd,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic [151:0] o_out_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [31:0]        r_id  [SLOTS];
    logic signed [15:0] r_x   [SLOTS];
    logic signed [15:0] r_y   [SLOTS];
    logic signed [15:0] r_sx  [SLOTS];
    logic signed [15:0] r_sy  [SLOTS];
    logic signed [15:0] r_dx  [SLOTS];
    logic signed [15:0] r_dy  [SLOTS];
    logic [7:0]         r_pr  [SLOTS];
    logic [SLOTS-1:0]   r_act, r_sta, r_end;

    logic [80:0]   r_req;
    logic [IW-1:0] r_sel;
    logic          r_hit;
    logic          r_valid;
    logic [151:0]  r_out;

    t_kind              w_kind;
    logic [31:0]        w_tid;
    logic signed [15:0] w_px, w_py;
    logic [7:0]         w_pr;
    logic [5:0]         w_qi;

    assign w_kind = t_kind'(r_req[2:0]);
    assign w_tid  = r_req[34:3];
    assign w_px   = r_req[50:35];
    assign w_py   = r_req[66:51];
    assign w_pr   = r_req[74:67];
    assign w_qi   = r_req[80:75];

    // Search: first id match, first free, nth active, first active id match.
    logic          s_hit;
    logic [IW-1:0] s_sel;
    always_comb begin
        logic          id_hit, fr_hit, nth_hit, aq_hit;
        logic [IW-1:0] id_sel, fr_sel, nth_sel, aq_sel;
        logic [6:0]    rank;
        id_hit = 1'b0; fr_hit = 1'b0; nth_hit = 1'b0; aq_hit = 1'b0;
        id_sel = '0; fr_sel = '0; nth_sel = '0; aq_sel = '0;
        rank = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!id_hit && r_id[i] == w_tid) begin
                id_hit = 1'b1; id_sel = IW'(i);
            end
            if (!fr_hit && !r_act[i] && !r_end[i]) begin
                fr_hit = 1'b1; fr_sel = IW'(i);
            end
            if (!aq_hit && r_act[i] && r_id[i] == w_tid) begin
                aq_hit = 1'b1; aq_sel = IW'(i);
            end
            if (r_act[i]) begin
                if (!nth_hit && rank == {1'b0, w_qi}) begin
                    nth_hit = 1'b1; nth_sel = IW'(i);
                end
                rank = rank + 7'd1;
            end
        end
        s_hit = 1'b0;
        s_sel = '0;
        case (w_kind)
            K_BEGIN: begin
                s_hit = id_hit | fr_hit;
                s_sel = id_hit ? id_sel : fr_sel;
            end
            K_MOVE: begin
                s_hit = id_hit & r_act[id_sel];
                s_sel = id_sel;
            end
            K_END: begin
                s_hit = id_hit;
                s_sel = id_sel;
            end
            K_NTH: begin
                s_hit = nth_hit;
                s_sel = nth_sel;
            end
            K_IDQ: begin
                s_hit = aq_hit;
                s_sel = aq_sel;
            end
            default: ;
        endcase
    end

    function automatic logic signed [15:0] sat16(input logic signed [16:0] d);
        logic signed [15:0] r;
        if (d > 17'sd32767) r = 16'sh7FFF;
        else if (d < -17'sd32768) r = 16'sh8000;
        else r = d[15:0];
        return r;
    endfunction

    logic signed [16:0] w_ddx, w_ddy;
    assign w_ddx = 17'(w_px) - 17'(r_x[r_sel]);
    assign w_ddy = 17'(w_py) - 17'(r_y[r_sel]);

    always_ff @(posedge i_clk) begin
        if (i_load) r_req <= i_req;
        if (i_cmd.search) begin
            r_sel <= s_sel;
            r_hit <= s_hit;
        end
        if (!i_rst_n) begin
            r_act <= '0; r_sta <= '0; r_end <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_id[i] <= '0; r_x[i] <= '0; r_y[i] <= '0; r_sx[i] <= '0;
                r_sy[i] <= '0; r_dx[i] <= '0; r_dy[i] <= '0; r_pr[i] <= '0;
            end
        end else if (i_cmd.apply) begin
            case (w_kind)
                K_BEGIN: if (r_hit) begin
                    r_id[r_sel] <= w_tid;
                    r_x[r_sel]  <= w_px;  r_y[r_sel]  <= w_py;
                    r_sx[r_sel] <= w_px;  r_sy[r_sel] <= w_py;
                    r_dx[r_sel] <= '0;    r_dy[r_sel] <= '0;
                    r_pr[r_sel] <= w_pr;
                    r_act[r_sel] <= 1'b1; r_sta[r_sel] <= 1'b1;
                    r_end[r_sel] <= 1'b0;
                end
                K_MOVE: if (r_hit) begin
                    r_dx[r_sel] <= sat16(w_ddx);
                    r_dy[r_sel] <= sat16(w_ddy);
                    r_x[r_sel]  <= w_px;  r_y[r_sel] <= w_py;
                    r_pr[r_sel] <= w_pr;
                end
                K_END: if (r_hit) begin
                    r_act[r_sel] <= 1'b0; r_end[r_sel] <= 1'b1;
                end
                K_TICK: begin
                    r_sta <= '0; r_end <= '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_dx[i] <= '0; r_dy[i] <= '0;
                    end
                end
                K_CLEAR: begin
                    r_act <= '0; r_sta <= '0; r_end <= '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_id[i] <= '0; r_x[i] <= '0; r_y[i] <= '0; r_sx[i] <= '0;
                        r_sy[i] <= '0; r_dx[i] <= '0; r_dy[i] <= '0; r_pr[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result assembly from the table as it stands after the apply step.
    logic [CW-1:0] w_cnt;
    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < SLOTS; i++) w_cnt = w_cnt + CW'(r_act[i]);
    end

    logic [151:0] w_res;
    always_comb begin
        w_res = '0;
        w_res[0]   = r_hit;
        w_res[7:1] = 7'(w_cnt);
        w_res[8]   = |r_sta;
        w_res[9]   = |r_end;
        if (r_hit) begin
            w_res[41:10]   = r_id[r_sel];
            w_res[57:42]   = r_x[r_sel];
            w_res[73:58]   = r_y[r_sel];
            w_res[89:74]   = r_sx[r_sel];
            w_res[105:90]  = r_sy[r_sel];
            w_res[121:106] = r_dx[r_sel];
            w_res[137:122] = r_dy[r_sel];
            w_res[145:138] = r_pr[r_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.result) r_out <= w_res;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/touch_slot_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_slot_tracker: table of touch contact slots
// Each request (begin, move, end, frame tick, clear, two queries, no-op) gives
// exactly one result carrying the affected slot and table summary.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_axis group, results leave on m_axis.
// One request is worked on at a time: it is taken while the sequencer is idle,
// then searched across all slots, applied, and its result is registered
// once the output register is free; the block accepts no new request until
// that result has been registered. The result sits in an output register;
// the next request may be taken while it waits, but its own result is held
// back until the register has been emptied. A stalled receiver therefore
// stalls the sequencer and then s_axis_tready.
// The search cycle is set by the priority scan over the slot table.
// Reset clears every slot at once and leaves both channels empty.
// ----------------------------------------------------------------------------
module touch_slot_tracker
    import tst_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[2:0], touch_id[34:3], pos_x[50:35], pos_y[66:51],
    // pressure_in[74:67], query_index[80:75], zero fill
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found[0], active_count[7:1], any_started[8], any_ended[9], out_id[41:10],
    // out_x, out_y, out_start_x, out_start_y, out_delta_x, out_delta_y
    // (16 bits each from bit 42), out_pressure[145:138], zero fill
    output logic [151:0] m_axis_tdata
);

    logic         w_busy;
    t_cmd         w_cmd;
    logic         w_acc;
    logic [151:0] w_out;

    assign s_axis_tready = !w_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    tst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc),
        .i_out_free (!m_axis_tvalid || m_axis_tready),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    tst_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_acc),
        .i_req       (s_axis_tdata[80:0]),
        .i_cmd       (w_cmd),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (w_out)
    );

    assign m_axis_tdata = w_out;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.search, w_cmd.apply, w_cmd.result}))
        else $error("controller issued overlapping commands");
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.search |-> !s_axis_tready)
        else $error("request accepted during search");
    a_result_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.result |=> m_axis_tvalid)
        else $error("result not presented");
    a_apply_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.search |=> w_cmd.apply)
        else $error("apply did not follow search");

endmodule

// ===== tb/tb_touch_slot_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_touch_slot_tracker: self-checking bench for the touch slot tracker
// Requests are sent over the input stream while a local slot table predicts
// each result. Results are compared field by field in order, under random
// idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_touch_slot_tracker;
    import tst_pkg::*;

    localparam int NSLOT     = 16;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [5:0]  qidx;
        logic [7:0]  pres;
        logic [15:0] py;
        logic [15:0] px;
        logic [31:0] tid;
        t_kind       kind;
    } t_req;

    typedef struct packed {
        logic [7:0]  pres;
        logic [15:0] dy;
        logic [15:0] dx;
        logic [15:0] sy;
        logic [15:0] sx;
        logic [15:0] y;
        logic [15:0] x;
        logic [31:0] id;
        logic        ended;
        logic        started;
        logic [6:0]  count;
        logic        found;
    } t_res;

    localparam logic [2:0] F_ACT = 3'b001;
    localparam logic [2:0] F_STA = 3'b010;
    localparam logic [2:0] F_END = 3'b100;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;

    touch_slot_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Predicted slot table.
    logic [31:0]       tab_id [NSLOT];
    logic signed [15:0] tab_x [NSLOT], tab_y [NSLOT], tab_sx [NSLOT], tab_sy [NSLOT];
    logic signed [15:0] tab_dx [NSLOT], tab_dy [NSLOT];
    logic [7:0]        tab_pres [NSLOT];
    logic [2:0]        tab_flag [NSLOT];

    t_res expected_results[$];
    int   send_idle_pct, recv_idle_pct;
    bit   hold_off;
    int   errors;
    int   cycles;
    logic [31:0] live_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_table();
        for (int i = 0; i < NSLOT; i++) begin
            tab_id[i] = '0; tab_x[i] = '0; tab_y[i] = '0; tab_sx[i] = '0;
            tab_sy[i] = '0; tab_dx[i] = '0; tab_dy[i] = '0; tab_pres[i] = '0;
            tab_flag[i] = '0;
        end
    endfunction

    function automatic logic signed [15:0] sat_sub(logic signed [15:0] a,
                                                   logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        if (d > 17'sd32767) return 16'sh7fff;
        if (d < -17'sd32768) return 16'sh8000;
        return d[15:0];
    endfunction

    function automatic int id_slot(logic [31:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (tab_id[i] == id) return i;
        return -1;
    endfunction

    function automatic t_res track_touch(t_req r);
        int   sel;
        int   rank;
        t_res o;
        sel  = -1;
        rank = 0;
        o    = '0;
        case (r.kind)
            K_BEGIN: begin
                sel = id_slot(r.tid);
                if (sel < 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (sel < 0 && (tab_flag[i] & (F_ACT | F_END)) == 0) sel = i;
                if (sel >= 0) begin
                    tab_id[sel] = r.tid; tab_x[sel] = r.px; tab_y[sel] = r.py;
                    tab_sx[sel] = r.px; tab_sy[sel] = r.py; tab_dx[sel] = '0;
                    tab_dy[sel] = '0; tab_pres[sel] = r.pres;
                    tab_flag[sel] = F_ACT | F_STA;
                end
            end
            K_MOVE: begin
                sel = id_slot(r.tid);
                if (sel >= 0 && tab_flag[sel][0]) begin
                    tab_dx[sel] = sat_sub(r.px, tab_x[sel]);
                    tab_dy[sel] = sat_sub(r.py, tab_y[sel]);
                    tab_x[sel] = r.px; tab_y[sel] = r.py; tab_pres[sel] = r.pres;
                end else begin
                    sel = -1;
                end
            end
            K_END: begin
                sel = id_slot(r.tid);
                if (sel >= 0) tab_flag[sel] = (tab_flag[sel] & ~F_ACT) | F_END;
            end
            K_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    tab_flag[i] &= F_ACT; tab_dx[i] = '0; tab_dy[i] = '0;
                end
            end
            K_CLEAR: clear_table();
            K_NTH: begin
                for (int i = 0; i < NSLOT; i++)
                    if (sel < 0 && tab_flag[i][0]) begin
                        if (rank == r.qidx) sel = i;
                        rank++;
                    end
            end
            K_IDQ: begin
                for (int i = 0; i < NSLOT; i++)
                    if (sel < 0 && tab_id[i] == r.tid && tab_flag[i][0]) sel = i;
            end
            default: ;
        endcase
        for (int i = 0; i < NSLOT; i++) begin
            o.count   += tab_flag[i][0];
            o.started |= tab_flag[i][1];
            o.ended   |= tab_flag[i][2];
        end
        if (sel >= 0) begin
            o.found = 1'b1; o.id = tab_id[sel]; o.x = tab_x[sel]; o.y = tab_y[sel];
            o.sx = tab_sx[sel]; o.sy = tab_sy[sel]; o.dx = tab_dx[sel];
            o.dy = tab_dy[sel]; o.pres = tab_pres[sel];
        end
        return o;
    endfunction

    // Sends one request, idling at random beforehand.
    task automatic send_request(t_req r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results = {expected_results, track_touch(r)};
        if (r.kind == K_BEGIN) live_ids = {live_ids, r.tid};
    endtask

    task automatic finish_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_results.size() > 0) @(posedge i_clk);
    endtask

    function automatic t_req make_req(t_kind k, logic [31:0] id, logic [15:0] x,
                                      logic [15:0] y, logic [7:0] p, logic [5:0] q);
        t_req r;
        r.kind = k; r.tid = id; r.px = x; r.py = y; r.pres = p; r.qidx = q;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req  r;
        int    c;
        r = t_req'(81'({$urandom, $urandom, $urandom}));
        c = $urandom_range(99);
        if (c < 25)      r.kind = K_BEGIN;
        else if (c < 50) r.kind = K_MOVE;
        else if (c < 62) r.kind = K_END;
        else if (c < 70) r.kind = K_TICK;
        else if (c < 72) r.kind = K_CLEAR;
        else if (c < 82) r.kind = K_NTH;
        else if (c < 92) r.kind = K_IDQ;
        else if (c < 94) r.kind = K_NONE;
        // Mostly reuse ids that have begun so that moves and ends hit slots.
        if (live_ids.size() > 0 && $urandom_range(9) < 8 && r.kind != K_NONE)
            r.tid = live_ids[$urandom_range(live_ids.size() - 1)];
        if ($urandom_range(3) == 0) r.tid = $urandom_range(20);
        if (live_ids.size() > 40) live_ids.delete(0);
        r.qidx = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(17));
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_req(K_IDQ, 32'd0, 16'd0, 16'd0, 8'd0, 6'd0));
        send_request(make_req(K_BEGIN, 32'd0, 16'h7fff, 16'h8000, 8'hff, 6'd0));
        send_request(make_req(K_MOVE, 32'd0, 16'h8000, 16'h7fff, 8'h00, 6'd0));
        send_request(make_req(K_MOVE, 32'd99, 16'h1, 16'h1, 8'h1, 6'd0));
        send_request(make_req(K_BEGIN, 32'hffffffff, 16'h1234, 16'hfedc, 8'h80, 6'h3f));
        send_request(make_req(K_NTH, 32'd0, 16'd0, 16'd0, 8'd0, 6'd1));
        send_request(make_req(K_NTH, 32'd0, 16'd0, 16'd0, 8'd0, 6'h3f));
        send_request(make_req(K_IDQ, 32'hffffffff, 16'd0, 16'd0, 8'd0, 6'd0));
        send_request(make_req(K_END, 32'd0, 16'd0, 16'd0, 8'd0, 6'd0));
        send_request(make_req(K_MOVE, 32'd0, 16'd5, 16'd5, 8'd5, 6'd0));
        send_request(make_req(K_END, 32'd1234, 16'd0, 16'd0, 8'd0, 6'd0));
        send_request(make_req(K_TICK, 32'd0, 16'd0, 16'd0, 8'd0, 6'd0));
        send_request(make_req(K_NONE, 32'd7, 16'd0, 16'd0, 8'd0, 6'd0));
        // Fill every slot so that a further begin finds no free slot.
        for (int i = 1; i <= NSLOT + 1; i++)
            send_request(make_req(K_BEGIN, 32'(i * 3 + 100), 16'(i), 16'(-i), 8'(i), 6'd0));
        send_request(make_req(K_CLEAR, 32'd0, 16'd0, 16'd0, 8'd0, 6'd0));
        finish_sending();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_request(random_req());
        finish_sending();
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_res got, want;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[145:0]);
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.found !== want.found) begin
                    $error("found exp %0d got %0d", want.found, got.found); errors++; end
                if (got.count !== want.count) begin
                    $error("active_count exp %0d got %0d", want.count, got.count); errors++; end
                if (got.started !== want.started) begin
                    $error("any_started exp %0d got %0d", want.started, got.started); errors++; end
                if (got.ended !== want.ended) begin
                    $error("any_ended exp %0d got %0d", want.ended, got.ended); errors++; end
                if (got.id !== want.id) begin
                    $error("out_id exp %h got %h", want.id, got.id); errors++; end
                if (got.x !== want.x) begin
                    $error("out_x exp %h got %h", want.x, got.x); errors++; end
                if (got.y !== want.y) begin
                    $error("out_y exp %h got %h", want.y, got.y); errors++; end
                if (got.sx !== want.sx) begin
                    $error("out_start_x exp %h got %h", want.sx, got.sx); errors++; end
                if (got.sy !== want.sy) begin
                    $error("out_start_y exp %h got %h", want.sy, got.sy); errors++; end
                if (got.dx !== want.dx) begin
                    $error("out_delta_x exp %h got %h", want.dx, got.dx); errors++; end
                if (got.dy !== want.dy) begin
                    $error("out_delta_y exp %h got %h", want.dy, got.dy); errors++; end
                if (got.pres !== want.pres) begin
                    $error("out_pressure exp %h got %h", want.pres, got.pres); errors++; end
            end
        end
    end

    initial begin
        errors        = 0;
        cycles        = 0;
        hold_off      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 83;
        clear_table();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(160);
        send_idle_pct = 83;
        recv_idle_pct = 19;
        test_random(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(140);
        test_backpressure();
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
